// File: rtl/bqc_pkg.sv
// Shared types, constants and register map of the two-section biquad high-pass filter.
// No dependencies; every other file refers to this package by scoped names.
package bqc_pkg;

  localparam int SECTIONS  = 2;
  localparam int SEC_W     = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 32;
  localparam int WORD_W    = 40;
  localparam int QSHIFT    = 30;

  // multiplier digit slicing of the delay word
  localparam int DIG_W     = 8;
  localparam int NDIG      = WORD_W / DIG_W;
  localparam int DCNT_W    = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int ACC_W     = COEF_W + DIG_W + 2;
  localparam int PROD_W    = COEF_W + WORD_W - QSHIFT;
  localparam int SUM_W     = PROD_W + 2;

  localparam int NUM_REGS  = 3 + 2 * SECTIONS;
  localparam int CFG_IDX_W = $clog2(NUM_REGS);

  localparam int REG_B0     = 0;
  localparam int REG_B1     = 1;
  localparam int REG_B2     = 2;
  localparam int REG_A_BASE = 3;

  localparam logic [COEF_W-1:0] RST_B0 = 32'h4000_0000;  //  1.0
  localparam logic [COEF_W-1:0] RST_B1 = 32'h8000_0000;  // -2.0
  localparam logic [COEF_W-1:0] RST_B2 = 32'h4000_0000;  //  1.0
  localparam logic [COEF_W-1:0] RST_A1 = 32'h8001_A371;  // -1.9999
  localparam logic [COEF_W-1:0] RST_A2 = 32'h3FFE_5C8F;  //  0.9999

  localparam logic signed [WORD_W-1:0]   W_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0]   W_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef struct packed {
    logic [COEF_W-1:0]                b0;
    logic [COEF_W-1:0]                b1;
    logic [COEF_W-1:0]                b2;
    logic [SECTIONS-1:0][COEF_W-1:0]  a1;
    logic [SECTIONS-1:0][COEF_W-1:0]  a2;
  } coef_t;

  typedef enum logic [2:0] {
    OP_A1W1,
    OP_A2W2,
    OP_B0W0,
    OP_B1W1,
    OP_B2W2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_MUL,
    ST_W0,
    ST_Y,
    ST_FIN
  } st_t;

endpackage

// File: rtl/bqc_if.sv
// Valid/ready channel interfaces for the filter's sample input and result output.
// Depends on bqc_pkg for field widths.
interface bqc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [bqc_pkg::SAMPLE_W-1:0]   sample_in;
  logic                                  last_in_block;

  modport source (output valid, output sample_in, output last_in_block, input ready);
  modport sink   (input valid, input sample_in, input last_in_block, output ready);
endinterface

interface bqc_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [bqc_pkg::SAMPLE_W-1:0]   sample_out;
  logic                                  last_in_block_res;
  logic                                  clipped;

  modport source (output valid, output sample_out, output last_in_block_res,
                  output clipped, input ready);
  modport sink   (input valid, input sample_out, input last_in_block_res,
                  input clipped, output ready);
endinterface

// File: rtl/bqc_cfg.sv
// Coefficient register file: shared numerator and per-section feedback terms.
// Depends on bqc_pkg for the register map and reset values.
module bqc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           we,
  input  logic [bqc_pkg::CFG_IDX_W-1:0]  idx,
  input  logic [bqc_pkg::COEF_W-1:0]     data,
  output bqc_pkg::coef_t                 coefs
);

  bqc_pkg::coef_t coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.b0 <= bqc_pkg::RST_B0;
      coef_r.b1 <= bqc_pkg::RST_B1;
      coef_r.b2 <= bqc_pkg::RST_B2;
      for (int s = 0; s < bqc_pkg::SECTIONS; s++) begin
        coef_r.a1[s] <= bqc_pkg::RST_A1;
        coef_r.a2[s] <= bqc_pkg::RST_A2;
      end
    end else if (we) begin
      if (idx == bqc_pkg::CFG_IDX_W'(bqc_pkg::REG_B0)) coef_r.b0 <= data;
      if (idx == bqc_pkg::CFG_IDX_W'(bqc_pkg::REG_B1)) coef_r.b1 <= data;
      if (idx == bqc_pkg::CFG_IDX_W'(bqc_pkg::REG_B2)) coef_r.b2 <= data;
      for (int s = 0; s < bqc_pkg::SECTIONS; s++) begin
        if (idx == bqc_pkg::CFG_IDX_W'(bqc_pkg::REG_A_BASE + 2 * s))
          coef_r.a1[s] <= data;
        if (idx == bqc_pkg::CFG_IDX_W'(bqc_pkg::REG_A_BASE + 2 * s + 1))
          coef_r.a2[s] <= data;
      end
    end
  end

  assign coefs = coef_r;

endmodule

// File: rtl/bqc_dmul.sv
// Digit-serial coefficient x delay-word multiplier with round-half-up to Q.15.
// Consumes the 40-bit word 8 bits per cycle, LSB digit first; depends on bqc_pkg.
module bqc_dmul (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [bqc_pkg::COEF_W-1:0]    coef,
  input  logic        [bqc_pkg::WORD_W-1:0]    word,
  output logic                                 done,
  output logic signed [bqc_pkg::PROD_W-1:0]    prod
);

  localparam int ACC_W = bqc_pkg::ACC_W;
  localparam int DIG_W = bqc_pkg::DIG_W;
  localparam int PP_W  = bqc_pkg::COEF_W + DIG_W + 1;
  localparam int HI_W  = bqc_pkg::PROD_W - (bqc_pkg::WORD_W - bqc_pkg::QSHIFT);
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (bqc_pkg::QSHIFT - 1);

  logic [bqc_pkg::WORD_W-1:0]      w_sr_r;
  logic [bqc_pkg::WORD_W-1:0]      low_r;
  logic signed [ACC_W-1:0]         acc_r;
  logic [bqc_pkg::DCNT_W-1:0]      dcnt_r;
  logic                            busy_r;
  logic                            done_r;

  logic                            active;
  logic                            last;
  logic [bqc_pkg::DCNT_W-1:0]      cur_idx;
  logic [bqc_pkg::WORD_W-1:0]      w_cur;
  logic [DIG_W-1:0]                digit;
  logic signed [DIG_W:0]           dig_s;
  logic signed [PP_W-1:0]          pp;
  logic signed [ACC_W-1:0]         acc_in;
  logic signed [ACC_W-1:0]         sum;

  always_comb begin
    active  = start || busy_r;
    cur_idx = start ? '0 : dcnt_r;
    last    = (cur_idx == bqc_pkg::DCNT_W'(bqc_pkg::NDIG - 1));
    w_cur   = start ? word : w_sr_r;
    digit   = w_cur[DIG_W-1:0];
    // only the top digit carries the word's sign
    dig_s   = last ? {digit[DIG_W-1], digit} : {1'b0, digit};
    pp      = PP_W'(coef) * PP_W'(dig_s);
    acc_in  = start ? RND : acc_r;
    sum     = acc_in + ACC_W'(pp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      dcnt_r <= '0;
    end else begin
      done_r <= active && last;
      busy_r <= active && !last;
      dcnt_r <= (active && !last) ? cur_idx + 1'b1 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      w_sr_r <= w_cur >> DIG_W;
      acc_r  <= sum >>> DIG_W;
      low_r  <= {sum[DIG_W-1:0], low_r[bqc_pkg::WORD_W-1:DIG_W]};
    end
  end

  assign done = done_r;
  assign prod = {acc_r[HI_W-1:0], low_r[bqc_pkg::WORD_W-1:bqc_pkg::QSHIFT]};

endmodule

// File: rtl/biquad_cascade_highpass_top.sv
// Top level of the two-section Direct Form II biquad high-pass filter.
// Depends on bqc_pkg, bqc_if, bqc_cfg and bqc_dmul.
//
// One Q1.15 sample in, one saturated Q1.15 sample out. Each sample costs ten
// coefficient x delay-word products, all run on one shared 32x8 digit-serial
// multiplier, plus per section a state for delay saturation (ST_W0) and one for
// the delay update (ST_Y), and a final state (ST_FIN) that hands the result to
// the output register. The next sample is taken the cycle after the result is
// handed to the output register. Samples are processed one at a time; a
// finished result waits in the output register while the next sample is
// accepted. The user must write coefficients through cfg_we/cfg_idx/cfg_data
// only while no sample is in flight; the block itself does not enforce it.
// Reset clears the delay words and loads the default high-pass coefficients.
module biquad_cascade_highpass_top (
  input  logic                           clk,
  input  logic                           rst_n,
  bqc_in_if.sink                         in_ch,
  bqc_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [bqc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bqc_pkg::COEF_W-1:0]     cfg_data
);

  localparam int SUM_W  = bqc_pkg::SUM_W;
  localparam int WORD_W = bqc_pkg::WORD_W;
  localparam int SMP_W  = bqc_pkg::SAMPLE_W;
  localparam int SEC_W  = bqc_pkg::SEC_W;

  bqc_pkg::coef_t                 coefs;
  bqc_pkg::st_t                   st_r, st_nxt;
  bqc_pkg::op_t                   op_r;
  logic [SEC_W-1:0]               sec_r;
  logic signed [SUM_W-1:0]        sum_r;
  logic signed [WORD_W-1:0]       w0_r;
  logic signed [WORD_W-1:0]       w1_r [bqc_pkg::SECTIONS];
  logic signed [WORD_W-1:0]       w2_r [bqc_pkg::SECTIONS];
  logic                           last_r;
  logic                           clip_r;
  logic signed [SMP_W-1:0]        res_r;
  logic                           out_valid_r;
  logic signed [SMP_W-1:0]        out_sample_r;
  logic                           out_last_r;
  logic                           out_clip_r;

  logic                           in_acc;
  logic                           out_load;
  logic                           mul_start;
  logic                           mul_done;
  logic signed [bqc_pkg::COEF_W-1:0] mul_coef;
  logic [WORD_W-1:0]              mul_word;
  logic signed [bqc_pkg::PROD_W-1:0] mul_prod;
  logic signed [SUM_W-1:0]        sum_acc;
  logic                           ovf_w;
  logic                           ovf_s;
  logic signed [WORD_W-1:0]       sat_w;
  logic signed [SMP_W-1:0]        sat_s;
  logic                           last_sec;

  bqc_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .idx   (cfg_idx),
    .data  (cfg_data),
    .coefs (coefs)
  );

  bqc_dmul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .coef  (mul_coef),
    .word  (mul_word),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign in_acc    = in_ch.valid && (st_r == bqc_pkg::ST_IDLE);
  assign mul_start = (st_r == bqc_pkg::ST_ISSUE);
  assign last_sec  = (sec_r == SEC_W'(bqc_pkg::SECTIONS - 1));
  assign out_load  = (st_r == bqc_pkg::ST_FIN) && (!out_valid_r || out_ch.ready);

  // operand select for the current product
  always_comb begin
    case (op_r)
      bqc_pkg::OP_A1W1: begin
        mul_coef = $signed(coefs.a1[sec_r]);
        mul_word = w1_r[sec_r];
      end
      bqc_pkg::OP_A2W2: begin
        mul_coef = $signed(coefs.a2[sec_r]);
        mul_word = w2_r[sec_r];
      end
      bqc_pkg::OP_B1W1: begin
        mul_coef = $signed(coefs.b1);
        mul_word = w1_r[sec_r];
      end
      bqc_pkg::OP_B2W2: begin
        mul_coef = $signed(coefs.b2);
        mul_word = w2_r[sec_r];
      end
      default: begin
        mul_coef = $signed(coefs.b0);
        mul_word = w0_r;
      end
    endcase
  end

  always_comb begin
    if (op_r == bqc_pkg::OP_A1W1 || op_r == bqc_pkg::OP_A2W2)
      sum_acc = sum_r - SUM_W'(mul_prod);
    else
      sum_acc = sum_r + SUM_W'(mul_prod);
    ovf_w = !((&sum_r[SUM_W-1:WORD_W-1]) || !(|sum_r[SUM_W-1:WORD_W-1]));
    ovf_s = !((&sum_r[SUM_W-1:SMP_W-1]) || !(|sum_r[SUM_W-1:SMP_W-1]));
    sat_w = ovf_w ? (sum_r[SUM_W-1] ? bqc_pkg::W_MIN : bqc_pkg::W_MAX) : sum_r[WORD_W-1:0];
    sat_s = ovf_s ? (sum_r[SUM_W-1] ? bqc_pkg::S_MIN : bqc_pkg::S_MAX) : sum_r[SMP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= bqc_pkg::ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      bqc_pkg::ST_IDLE:  if (in_acc) st_nxt = bqc_pkg::ST_ISSUE;
      bqc_pkg::ST_ISSUE: st_nxt = bqc_pkg::ST_MUL;
      bqc_pkg::ST_MUL: begin
        if (mul_done) begin
          if (op_r == bqc_pkg::OP_A2W2)      st_nxt = bqc_pkg::ST_W0;
          else if (op_r == bqc_pkg::OP_B2W2) st_nxt = bqc_pkg::ST_Y;
          else                               st_nxt = bqc_pkg::ST_ISSUE;
        end
      end
      bqc_pkg::ST_W0:    st_nxt = bqc_pkg::ST_ISSUE;
      bqc_pkg::ST_Y:     st_nxt = last_sec ? bqc_pkg::ST_FIN : bqc_pkg::ST_ISSUE;
      bqc_pkg::ST_FIN:   if (out_load) st_nxt = bqc_pkg::ST_IDLE;
      default:           st_nxt = bqc_pkg::ST_IDLE;
    endcase
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    case (st_r)
      bqc_pkg::ST_IDLE: begin
        if (in_acc) begin
          sum_r  <= SUM_W'(in_ch.sample_in);
          last_r <= in_ch.last_in_block;
          clip_r <= 1'b0;
          sec_r  <= '0;
          op_r   <= bqc_pkg::OP_A1W1;
        end
      end
      bqc_pkg::ST_MUL: begin
        if (mul_done) begin
          sum_r <= sum_acc;
          case (op_r)
            bqc_pkg::OP_A1W1: op_r <= bqc_pkg::OP_A2W2;
            bqc_pkg::OP_B0W0: op_r <= bqc_pkg::OP_B1W1;
            bqc_pkg::OP_B1W1: op_r <= bqc_pkg::OP_B2W2;
            default:          op_r <= op_r;
          endcase
        end
      end
      bqc_pkg::ST_W0: begin
        w0_r   <= sat_w;
        clip_r <= clip_r | ovf_w;
        sum_r  <= '0;
        op_r   <= bqc_pkg::OP_B0W0;
      end
      bqc_pkg::ST_Y: begin
        if (last_sec) begin
          res_r  <= sat_s;
          clip_r <= clip_r | ovf_s;
        end else begin
          // section output becomes the next section's input
          sum_r  <= SUM_W'(sat_w);
          clip_r <= clip_r | ovf_w;
          sec_r  <= sec_r + 1'b1;
          op_r   <= bqc_pkg::OP_A1W1;
        end
      end
      default: begin
      end
    endcase
  end

  // delay line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < bqc_pkg::SECTIONS; s++) begin
        w1_r[s] <= '0;
        w2_r[s] <= '0;
      end
    end else if (st_r == bqc_pkg::ST_Y) begin
      w2_r[sec_r] <= w1_r[sec_r];
      w1_r[sec_r] <= w0_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= res_r;
      out_last_r   <= last_r;
      out_clip_r   <= clip_r;
    end
  end

  assign in_ch.ready              = (st_r == bqc_pkg::ST_IDLE);
  assign out_ch.valid             = out_valid_r;
  assign out_ch.sample_out        = out_sample_r;
  assign out_ch.last_in_block_res = out_last_r;
  assign out_ch.clipped           = out_clip_r;

endmodule

// File: rtl/bqc_checker.sv
// Port-level checks for the biquad filter top level, attached with bind.
// Depends on bqc_pkg and on the top level's channel interfaces.
module bqc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [bqc_pkg::SAMPLE_W-1:0] out_sample,
  input logic                                out_last,
  input logic                                out_clip
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sample) && $stable(out_last) && $stable(out_clip))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("item accepted while previous item still in work");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without a pending item");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more than two items in flight");

endmodule

bind biquad_cascade_highpass_top bqc_checker u_bqc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_sample (out_ch.sample_out),
  .out_last   (out_ch.last_in_block_res),
  .out_clip   (out_ch.clipped)
);

// File: tb/tb_top.sv
// Self-checking testbench for the two-section biquad high-pass filter. Depends on bqc_pkg,
// bqc_if and biquad_cascade_highpass_top; a bit-exact predictor or a typed want checks
// every result over directed samples and random coefficient phases under random stalls.
`timescale 1ns / 1ps

module tb_top;

  localparam int SAMPLE_W   = bqc_pkg::SAMPLE_W;
  localparam int COEF_W     = bqc_pkg::COEF_W;
  localparam int WORD_W     = bqc_pkg::WORD_W;
  localparam int CFG_IDX_W  = bqc_pkg::CFG_IDX_W;
  localparam int NUM_REGS   = bqc_pkg::NUM_REGS;
  localparam int SECTIONS   = bqc_pkg::SECTIONS;
  localparam int QSHIFT     = bqc_pkg::QSHIFT;
  localparam int REG_B0     = bqc_pkg::REG_B0;
  localparam int REG_B1     = bqc_pkg::REG_B1;
  localparam int REG_B2     = bqc_pkg::REG_B2;
  localparam int REG_A_BASE = bqc_pkg::REG_A_BASE;

  localparam logic [COEF_W-1:0] RST_B0 = bqc_pkg::RST_B0;
  localparam logic [COEF_W-1:0] RST_B1 = bqc_pkg::RST_B1;
  localparam logic [COEF_W-1:0] RST_B2 = bqc_pkg::RST_B2;
  localparam logic [COEF_W-1:0] RST_A1 = bqc_pkg::RST_A1;
  localparam logic [COEF_W-1:0] RST_A2 = bqc_pkg::RST_A2;

  localparam logic signed [WORD_W-1:0]   W_MAX = bqc_pkg::W_MAX;
  localparam logic signed [WORD_W-1:0]   W_MIN = bqc_pkg::W_MIN;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = bqc_pkg::S_MAX;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = bqc_pkg::S_MIN;

  localparam int CYCLE_LIMIT = 600_000;
  localparam int PHASE_ITEMS = 48;
  localparam int NUM_PHASES  = 10;
  localparam int DRAIN_WAIT  = 80;
  localparam int REG_NONE    = NUM_REGS;  // no register at this index

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       last;
    logic                       clip;
  } result_t;

  // directed row: sample repeated reps times; grow loads the runaway set first
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       last;
    logic [4:0]                 reps;
    logic                       grow;
    logic                       typed;
    result_t                    want;
  } dir_row_t;

  typedef enum int {
    SET_DEFAULT,
    SET_STABLE,
    SET_FIR,
    SET_WILD,
    SET_EDGE,
    SET_GROW
  } coef_set_t;

  localparam dir_row_t DIR_TAB [10] = '{
    '{16'sh7FFF, 1'b1, 5'd1,  1'b0, 1'b1, '{16'sh7FFF, 1'b1, 1'b0}},
    '{16'sh8000, 1'b0, 5'd1,  1'b0, 1'b0, '0},
    '{16'sh0000, 1'b1, 5'd1,  1'b0, 1'b0, '0},
    '{16'shFFFF, 1'b0, 5'd1,  1'b0, 1'b0, '0},
    '{16'sh0001, 1'b1, 5'd1,  1'b0, 1'b0, '0},
    '{16'sh5555, 1'b0, 5'd1,  1'b0, 1'b0, '0},
    '{16'shAAAA, 1'b1, 5'd1,  1'b0, 1'b0, '0},
    '{16'sh7FFF, 1'b0, 5'd12, 1'b1, 1'b0, '0},
    '{16'sh8000, 1'b1, 5'd2,  1'b0, 1'b0, '0},
    '{16'sh7FFF, 1'b0, 5'd3,  1'b0, 1'b0, '0}
  };

  // FIR phases follow the unstable ones so the delay words get flushed
  localparam coef_set_t PHASE_PLAN [NUM_PHASES] = '{
    SET_FIR, SET_STABLE, SET_WILD, SET_FIR, SET_EDGE,
    SET_FIR, SET_DEFAULT, SET_EDGE, SET_FIR, SET_STABLE
  };

  localparam logic [COEF_W-1:0] EDGE_VALS [7] = '{
    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h4000_0000,
    32'hC000_0000, 32'hFFFF_FFFF, 32'h0000_0001
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [COEF_W-1:0] cfg_data;

  bqc_in_if  in_bus ();
  bqc_out_if out_bus ();

  biquad_cascade_highpass_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // filter image: coefficient registers and delay words
  logic signed [COEF_W-1:0] coef_reg [NUM_REGS];
  logic signed [WORD_W-1:0] delay_word [2*SECTIONS];

  result_t pending_q [$];
  result_t want_res;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int stall_left = 0;
  bit idle_on = 1'b1;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 60);
  endfunction

  // coefficient x word, rounded half up to Q.15
  function automatic logic signed [63:0] q30_mul(input logic signed [COEF_W-1:0] c,
                                                 input logic signed [WORD_W-1:0] w);
    logic signed [79:0] p;
    p = 80'(c) * 80'(w);
    p = (p + 80'sd536870912) >>> QSHIFT;
    return p[63:0];
  endfunction

  function automatic logic signed [63:0] clamp(input logic signed [63:0] v, lo, hi,
                                               inout logic clip);
    if (v > hi) begin
      clip = 1'b1;
      return hi;
    end
    if (v < lo) begin
      clip = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic result_t hpf_step(input logic signed [SAMPLE_W-1:0] smp,
                                       input logic last);
    logic signed [63:0] x, w0, w1, w2, y;
    logic clip;
    result_t r;
    x = 64'(smp);
    clip = 1'b0;
    for (int s = 0; s < SECTIONS; s++) begin
      w1 = 64'(delay_word[2*s]);
      w2 = 64'(delay_word[2*s+1]);
      w0 = x - q30_mul(coef_reg[REG_A_BASE+2*s], w1[WORD_W-1:0])
             - q30_mul(coef_reg[REG_A_BASE+2*s+1], w2[WORD_W-1:0]);
      w0 = clamp(w0, 64'(W_MIN), 64'(W_MAX), clip);
      y = q30_mul(coef_reg[REG_B0], w0[WORD_W-1:0])
        + q30_mul(coef_reg[REG_B1], w1[WORD_W-1:0])
        + q30_mul(coef_reg[REG_B2], w2[WORD_W-1:0]);
      if (s == SECTIONS - 1) y = clamp(y, 64'(S_MIN), 64'(S_MAX), clip);
      else y = clamp(y, 64'(W_MIN), 64'(W_MAX), clip);
      delay_word[2*s+1] = w1[WORD_W-1:0];
      delay_word[2*s]   = w0[WORD_W-1:0];
      x = y;
    end
    r.smp  = x[SAMPLE_W-1:0];
    r.last = last;
    r.clip = clip;
    return r;
  endfunction

  task automatic report_error(input string msg);
    err_cnt++;
    if (err_cnt <= 100) $display("cycle %0d: %s", cycle_cnt, msg);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic write_reg(input int idx, input logic [COEF_W-1:0] val);
    cfg_we   = 1'b1;
    cfg_idx  = idx[CFG_IDX_W-1:0];
    cfg_data = val;
    if (idx < NUM_REGS) coef_reg[idx] = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_coefs(input coef_set_t kind);
    logic [COEF_W-1:0] v [NUM_REGS];
    longint a1, a2, lim;
    for (int i = 0; i < NUM_REGS; i++) v[i] = $urandom();
    case (kind)
      SET_DEFAULT: begin
        v[REG_B0] = RST_B0;
        v[REG_B1] = RST_B1;
        v[REG_B2] = RST_B2;
        for (int s = 0; s < SECTIONS; s++) begin
          v[REG_A_BASE+2*s]   = RST_A1;
          v[REG_A_BASE+2*s+1] = RST_A2;
        end
      end
      SET_GROW: begin
        // maximal positive feedback: the words double and more each step
        for (int i = 0; i < NUM_REGS; i++)
          v[i] = (i < REG_A_BASE) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
      SET_FIR: begin
        for (int i = REG_A_BASE; i < NUM_REGS; i++) v[i] = '0;
      end
      SET_EDGE: begin
        for (int i = 0; i < NUM_REGS; i++) v[i] = EDGE_VALS[$urandom_range(0, 6)];
      end
      SET_STABLE: begin
        for (int i = REG_B0; i <= REG_B2; i++)
          v[i] = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        // poles inside the unit circle: |a2| < 0.9, |a1| < 0.95 * (1 + a2)
        for (int s = 0; s < SECTIONS; s++) begin
          a2 = longint'($urandom_range(0, 1932735282)) - 966367641;
          lim = ((longint'(1) << 30) + a2) * 95 / 100;
          a1 = longint'($urandom_range(0, 32'(2 * lim))) - lim;
          v[REG_A_BASE+2*s]   = a1[COEF_W-1:0];
          v[REG_A_BASE+2*s+1] = a2[COEF_W-1:0];
        end
      end
      default: ;
    endcase
    for (int i = 0; i < NUM_REGS; i++) write_reg(i, v[i]);
    write_reg(REG_NONE, $urandom());
  endtask

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic last,
                             input bit typed, input result_t want);
    result_t calc;
    int gap;
    gap = (idle_on && $urandom_range(0, 9) < 4) ? pick_gap() : 0;
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid         = 1'b1;
    in_bus.sample_in     = smp;
    in_bus.last_in_block = last;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    calc = hpf_step(smp, last);
    pending_q.push_back(typed ? want : calc);
    @(negedge clk);
  endtask

  task automatic drain();
    in_bus.valid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!idle_on) begin
      out_bus.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_bus.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_bus.ready <= 1'b0;
      stall_left <= pick_gap() - 1;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pending_q.size() == 0) begin
        report_error($sformatf("result y=%0d with nothing pending", out_bus.sample_out));
      end else begin
        want_res = pending_q.pop_front();
        if (out_bus.sample_out !== want_res.smp ||
            out_bus.last_in_block_res !== want_res.last ||
            out_bus.clipped !== want_res.clip)
          report_error($sformatf(
            "mismatch: got y=%0d last=%0b clip=%0b, want y=%0d last=%0b clip=%0b",
            out_bus.sample_out, out_bus.last_in_block_res, out_bus.clipped,
            want_res.smp, want_res.last, want_res.clip));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    int r;
    logic signed [SAMPLE_W-1:0] smp, prev_smp;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = '0;
    cfg_data             = '0;
    in_bus.valid         = 1'b0;
    in_bus.sample_in     = '0;
    in_bus.last_in_block = 1'b0;
    out_bus.ready        = 1'b0;
    prev_smp             = '0;

    coef_reg[REG_B0] = RST_B0;
    coef_reg[REG_B1] = RST_B1;
    coef_reg[REG_B2] = RST_B2;
    for (int s = 0; s < SECTIONS; s++) begin
      coef_reg[REG_A_BASE+2*s]   = RST_A1;
      coef_reg[REG_A_BASE+2*s+1] = RST_A2;
    end
    for (int i = 0; i < 2 * SECTIONS; i++) delay_word[i] = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // a write to the unused index must not disturb the reset coefficients
    write_reg(REG_NONE, 32'h0000_0000);
    foreach (DIR_TAB[k]) begin
      if (DIR_TAB[k].grow) begin
        drain();
        load_coefs(SET_GROW);
      end
      repeat (DIR_TAB[k].reps)
        send_sample(DIR_TAB[k].smp, DIR_TAB[k].last, DIR_TAB[k].typed, DIR_TAB[k].want);
    end
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      idle_on = (ph % 4 != 3);
      load_coefs(PHASE_PLAN[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          case ($urandom_range(0, 3))
            0:       smp = 16'sh7FFF;
            1:       smp = 16'sh8000;
            2:       smp = 16'sh0000;
            default: smp = 16'shFFFF;
          endcase
        end else if (r < 25) begin
          smp = SAMPLE_W'($urandom_range(0, 128) - 64);
        end else if (r < 35) begin
          smp = prev_smp;
        end else begin
          smp = SAMPLE_W'($urandom());
        end
        prev_smp = smp;
        send_sample(smp, ($urandom_range(0, 7) == 0), 1'b0, '0);
      end
      drain();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/bqc_pkg.sv
rtl/bqc_if.sv
rtl/bqc_cfg.sv
rtl/bqc_dmul.sv
rtl/biquad_cascade_highpass_top.sv
rtl/bqc_checker.sv
tb/tb_top.sv
